[rtl/xbin_pkg.sv]
`default_nettype none

package xbin_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_CELL    = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_BADSIG  = 2'd2;

    // Run types held in bits 7-6 of a run byte.
    localparam logic [1:0] RUN_PAIRS      = 2'd0;
    localparam logic [1:0] RUN_CHAR_ATTRS = 2'd1;
    localparam logic [1:0] RUN_ATTR_CHARS = 2'd2;
    localparam logic [1:0] RUN_REPEAT     = 2'd3;

    // Five-byte file signature, "XBIN" followed by 0x1A; entry 0 comes first.
    localparam logic [4:0][7:0] SIGNATURE = {8'h1A, 8'h4E, 8'h49, 8'h42, 8'h58};

    // One result item as it leaves the output register.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cell_column;
        logic [15:0] cell_row;
        logic [7:0]  glyph_code;
        logic [3:0]  fore_index;
        logic [3:0]  back_index;
        logic [3:0]  color_slot;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
        logic        run_end;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;   // an input byte transfers this cycle
        logic step;   // emit one cell of a repeated run
        logic load;   // capture a result into the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic has_result;     // the current byte produces one result
        logic starts_expand;  // the current byte opens a repeated run
        logic step_last;      // the current repeated cell is the last one
    } stat_t;

endpackage

`default_nettype wire

[rtl/xbin_byte_if.sv]
`default_nettype none

interface xbin_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[rtl/xbin_result_if.sv]
`default_nettype none

interface xbin_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] cell_column;
    logic [15:0] cell_row;
    logic [7:0]  glyph_code;
    logic [3:0]  fore_index;
    logic [3:0]  back_index;
    logic [3:0]  color_slot;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic        run_end;

    modport source (
        output valid, input ready,
        output kind, output cell_column, output cell_row, output glyph_code,
        output fore_index, output back_index, output color_slot,
        output red_level, output green_level, output blue_level, output run_end
    );
    modport sink (
        input valid, output ready,
        input kind, input cell_column, input cell_row, input glyph_code,
        input fore_index, input back_index, input color_slot,
        input red_level, input green_level, input blue_level, input run_end
    );
endinterface

`default_nettype wire

[rtl/xbin_datapath.sv]
`default_nettype none

module xbin_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire xbin_pkg::cmd_t  cmd,
    input  wire logic [7:0]      data_byte,
    input  wire logic            final_byte,
    output xbin_pkg::stat_t      stat,
    output xbin_pkg::result_t    result
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_FONT    = 3'd2;
    localparam logic [2:0] PH_CELLS   = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_BAD     = 3'd5;

    // Widen a 6-bit palette channel to 8 bits.
    function automatic logic [7:0] widen(input logic [7:0] v);
        widen = {v[5:0], 2'b00} | {4'b0000, v[7:4]};
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [16:0] byte_count_reg, byte_count_next;
    logic [1:0]  pal_chan_reg, pal_chan_next;
    logic [3:0]  pal_slot_reg, pal_slot_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  glyph_height_reg, glyph_height_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  held_red_reg, held_red_next;
    logic [7:0]  held_green_reg, held_green_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  run_type_reg, run_type_next;
    logic [6:0]  run_left_reg, run_left_next;
    logic [7:0]  held_char_reg, held_char_next;
    logic [7:0]  held_attr_reg, held_attr_next;
    logic        have_char_reg, have_char_next;
    logic        have_attr_reg, have_attr_next;
    logic        final_hold_reg, final_hold_next;
    xbin_pkg::result_t result_reg, result_next;

    logic [16:0] font_len;
    logic [16:0] count_inc;
    logic        cell_emit;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [15:0] column_inc;
    logic [15:0] row_inc;
    logic        row_wrap;
    logic        height_hit;
    logic        step_last;
    logic        go_font;
    logic        clear_all;

    assign font_len  = flags_reg[4] ? {glyph_height_reg, 9'b0} : {1'b0, glyph_height_reg, 8'b0};
    assign count_inc = byte_count_reg + 17'd1;

    // Cell position advance, shared by both emit paths.
    assign column_inc = column_reg + 16'd1;
    assign row_inc    = row_reg + 16'd1;
    assign row_wrap   = (column_inc == width_reg);
    assign height_hit = row_wrap && (row_inc == height_reg);

    assign step_last = (run_left_reg == 7'd1) || height_hit;

    // Next state for a transferred byte or a repeated cell.
    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        pal_chan_next     = pal_chan_reg;
        pal_slot_next     = pal_slot_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        glyph_height_next = glyph_height_reg;
        flags_next        = flags_reg;
        held_red_next     = held_red_reg;
        held_green_next   = held_green_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        run_type_next     = run_type_reg;
        run_left_next     = run_left_reg;
        held_char_next    = held_char_reg;
        held_attr_next    = held_attr_reg;
        have_char_next    = have_char_reg;
        have_attr_next    = have_attr_reg;
        final_hold_next   = final_hold_reg;
        result_next         = '0;
        result_next.run_end = 1'b1;
        stat.has_result    = 1'b0;
        stat.starts_expand = 1'b0;
        stat.step_last     = step_last;
        cell_emit = 1'b0;
        cell_char = held_char_reg;
        cell_attr = held_attr_reg;
        go_font   = 1'b0;
        clear_all = 1'b0;

        if (cmd.step)
        begin
            cell_emit     = 1'b1;
            run_left_next = run_left_reg - 7'd1;
            result_next.run_end = step_last;
            clear_all     = step_last && final_hold_reg;
        end
        else if (cmd.take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (byte_count_reg < 17'd5)
                    begin
                        if (data_byte != xbin_pkg::SIGNATURE[byte_count_reg[2:0]])
                        begin
                            stat.has_result  = 1'b1;
                            result_next.kind = xbin_pkg::KIND_BADSIG;
                            phase_next       = PH_BAD;
                        end
                        else
                        begin
                            byte_count_next = count_inc;
                        end
                    end
                    else if (byte_count_reg < 17'd10)
                    begin
                        case (byte_count_reg[3:0])
                            4'd5:    width_next[7:0]   = data_byte;
                            4'd6:    width_next[15:8]  = data_byte;
                            4'd7:    height_next[7:0]  = data_byte;
                            4'd8:    height_next[15:8] = data_byte;
                            default: glyph_height_next = data_byte;
                        endcase
                        byte_count_next = count_inc;
                    end
                    else
                    begin
                        flags_next      = data_byte;
                        byte_count_next = '0;
                        pal_chan_next   = '0;
                        pal_slot_next   = '0;
                        if (data_byte[0])
                            phase_next = PH_PALETTE;
                        else
                            go_font = data_byte[1] && (glyph_height_reg != 8'd0);
                        if (!data_byte[0] && !go_font)
                        begin
                            run_left_next  = '0;
                            have_char_next = 1'b0;
                            have_attr_next = 1'b0;
                            column_next    = '0;
                            row_next       = '0;
                            phase_next     = (height_reg == 16'd0) ? PH_DONE : PH_CELLS;
                        end
                        else if (go_font)
                        begin
                            phase_next = PH_FONT;
                        end
                    end
                end

                PH_PALETTE:
                begin
                    case (pal_chan_reg)
                        2'd0:    held_red_next   = data_byte;
                        2'd1:    held_green_next = data_byte;
                        default:
                        begin
                            stat.has_result         = 1'b1;
                            result_next.kind        = xbin_pkg::KIND_PALETTE;
                            result_next.color_slot  = pal_slot_reg;
                            result_next.red_level   = widen(held_red_reg);
                            result_next.green_level = widen(held_green_reg);
                            result_next.blue_level  = widen(data_byte);
                        end
                    endcase
                    pal_chan_next = (pal_chan_reg == 2'd2) ? 2'd0 : pal_chan_reg + 2'd1;
                    if (pal_chan_reg == 2'd2)
                        pal_slot_next = pal_slot_reg + 4'd1;
                    if (pal_chan_reg == 2'd2 && pal_slot_reg == 4'd15)
                    begin
                        byte_count_next = '0;
                        if (flags_reg[1] && glyph_height_reg != 8'd0)
                        begin
                            phase_next = PH_FONT;
                        end
                        else
                        begin
                            run_left_next  = '0;
                            have_char_next = 1'b0;
                            have_attr_next = 1'b0;
                            column_next    = '0;
                            row_next       = '0;
                            phase_next     = (height_reg == 16'd0) ? PH_DONE : PH_CELLS;
                        end
                    end
                end

                PH_FONT:
                begin
                    byte_count_next = count_inc;
                    if (count_inc >= font_len)
                    begin
                        byte_count_next = '0;
                        run_left_next   = '0;
                        have_char_next  = 1'b0;
                        have_attr_next  = 1'b0;
                        column_next     = '0;
                        row_next        = '0;
                        phase_next      = (height_reg == 16'd0) ? PH_DONE : PH_CELLS;
                    end
                end

                PH_CELLS:
                begin
                    if (!flags_reg[2])
                    begin
                        // Raw character and attribute pairs.
                        if (!have_char_reg)
                        begin
                            held_char_next = data_byte;
                            have_char_next = 1'b1;
                        end
                        else
                        begin
                            held_attr_next = data_byte;
                            have_char_next = 1'b0;
                            cell_emit      = 1'b1;
                            cell_attr      = data_byte;
                        end
                    end
                    else if (run_left_reg == 7'd0)
                    begin
                        // Run header byte.
                        run_type_next  = data_byte[7:6];
                        run_left_next  = {1'b0, data_byte[5:0]} + 7'd1;
                        have_char_next = 1'b0;
                        have_attr_next = 1'b0;
                    end
                    else
                    begin
                        case (run_type_reg)
                            xbin_pkg::RUN_PAIRS:
                            begin
                                if (!have_char_reg)
                                begin
                                    held_char_next = data_byte;
                                    have_char_next = 1'b1;
                                end
                                else
                                begin
                                    cell_emit      = 1'b1;
                                    cell_attr      = data_byte;
                                    have_char_next = 1'b0;
                                    run_left_next  = run_left_reg - 7'd1;
                                end
                            end
                            xbin_pkg::RUN_CHAR_ATTRS:
                            begin
                                if (!have_char_reg)
                                begin
                                    held_char_next = data_byte;
                                    have_char_next = 1'b1;
                                end
                                else
                                begin
                                    held_attr_next = data_byte;
                                    cell_emit      = 1'b1;
                                    cell_attr      = data_byte;
                                    run_left_next  = run_left_reg - 7'd1;
                                end
                            end
                            xbin_pkg::RUN_ATTR_CHARS:
                            begin
                                if (!have_attr_reg)
                                begin
                                    held_attr_next = data_byte;
                                    have_attr_next = 1'b1;
                                end
                                else
                                begin
                                    held_char_next = data_byte;
                                    cell_emit      = 1'b1;
                                    cell_char      = data_byte;
                                    run_left_next  = run_left_reg - 7'd1;
                                end
                            end
                            default:
                            begin
                                // Repeated cell: the attribute byte opens the expansion.
                                if (!have_char_reg)
                                begin
                                    held_char_next = data_byte;
                                    have_char_next = 1'b1;
                                end
                                else
                                begin
                                    held_attr_next     = data_byte;
                                    have_attr_next     = 1'b1;
                                    stat.starts_expand = 1'b1;
                                    final_hold_next    = final_byte;
                                end
                            end
                        endcase
                    end
                end

                default:
                begin
                end
            endcase

            clear_all = final_byte && !stat.starts_expand;
        end

        // Cell result and position advance.
        if (cell_emit)
        begin
            stat.has_result         = 1'b1;
            result_next.kind        = xbin_pkg::KIND_CELL;
            result_next.cell_column = column_reg;
            result_next.cell_row    = row_reg;
            result_next.glyph_code  = cell_char;
            result_next.fore_index  = cell_attr[3:0];
            result_next.back_index  = cell_attr[7:4];
            column_next             = row_wrap ? 16'd0 : column_inc;
            if (row_wrap)
                row_next = row_inc;
            if (height_hit)
                phase_next = PH_DONE;
        end

        // End of file returns everything to the header state.
        if (clear_all)
        begin
            phase_next        = PH_HEADER;
            byte_count_next   = '0;
            pal_chan_next     = '0;
            pal_slot_next     = '0;
            width_next        = '0;
            height_next       = '0;
            glyph_height_next = '0;
            flags_next        = '0;
            held_red_next     = '0;
            held_green_next   = '0;
            column_next       = '0;
            row_next          = '0;
            run_type_next     = '0;
            run_left_next     = '0;
            held_char_next    = '0;
            held_attr_next    = '0;
            have_char_next    = 1'b0;
            have_attr_next    = 1'b0;
            final_hold_next   = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            byte_count_reg   <= '0;
            pal_chan_reg     <= '0;
            pal_slot_reg     <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            glyph_height_reg <= '0;
            flags_reg        <= '0;
            held_red_reg     <= '0;
            held_green_reg   <= '0;
            column_reg       <= '0;
            row_reg          <= '0;
            run_type_reg     <= '0;
            run_left_reg     <= '0;
            held_char_reg    <= '0;
            held_attr_reg    <= '0;
            have_char_reg    <= 1'b0;
            have_attr_reg    <= 1'b0;
            final_hold_reg   <= 1'b0;
        end
        else if (cmd.take || cmd.step)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            pal_chan_reg     <= pal_chan_next;
            pal_slot_reg     <= pal_slot_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            glyph_height_reg <= glyph_height_next;
            flags_reg        <= flags_next;
            held_red_reg     <= held_red_next;
            held_green_reg   <= held_green_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            run_type_reg     <= run_type_next;
            run_left_reg     <= run_left_next;
            held_char_reg    <= held_char_next;
            held_attr_reg    <= held_attr_next;
            have_char_reg    <= have_char_next;
            have_attr_reg    <= have_attr_next;
            final_hold_reg   <= final_hold_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/xbin_control.sv]
`default_nettype none

module xbin_control (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire xbin_pkg::stat_t stat,
    output xbin_pkg::cmd_t       cmd
);

    localparam logic ST_BYTE   = 1'b0;
    localparam logic ST_EXPAND = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_BYTE) && out_free;

    assign cmd.take = in_valid && in_ready;
    assign cmd.step = (state_reg == ST_EXPAND) && out_free;
    assign cmd.load = (cmd.take && stat.has_result) || cmd.step;

    // Sequencing between byte intake and run expansion.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BYTE:
            begin
                if (cmd.take && stat.starts_expand)
                    state_next = ST_EXPAND;
            end
            ST_EXPAND:
            begin
                if (cmd.step && stat.step_last)
                    state_next = ST_BYTE;
            end
            default:
            begin
                state_next = ST_BYTE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BYTE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/xbin_stream_decoder.sv]
`default_nettype none

// Channel      Role    Payload
// file_bytes   sink    data_byte, final_byte
// results      source  kind, cell_column, cell_row, glyph_code, fore_index,
//                      back_index, color_slot, red/green/blue_level, run_end
//
// One byte transfers per cycle while the output register is free; each byte
// gives at most one result, except the attribute byte of a repeated run,
// which emits its 1 to 64 cells at one per cycle while the output is free,
// holding input off. The output register is the only buffer: while a result
// waits there, the next byte is held off until the receiver takes it.
// Reset (rst_n, asynchronous, active low) returns the parser to the header.

module xbin_stream_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    xbin_byte_if.sink   file_bytes,
    xbin_result_if.source results
);

    xbin_pkg::cmd_t    cmd;
    xbin_pkg::stat_t   stat;
    xbin_pkg::result_t result;

    xbin_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (file_bytes.valid),
        .in_ready  (file_bytes.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xbin_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (file_bytes.data_byte),
        .final_byte (file_bytes.final_byte),
        .stat       (stat),
        .result     (result)
    );

    // Result fields onto the output channel.
    assign results.kind        = result.kind;
    assign results.cell_column = result.cell_column;
    assign results.cell_row    = result.cell_row;
    assign results.glyph_code  = result.glyph_code;
    assign results.fore_index  = result.fore_index;
    assign results.back_index  = result.back_index;
    assign results.color_slot  = result.color_slot;
    assign results.red_level   = result.red_level;
    assign results.green_level = result.green_level;
    assign results.blue_level  = result.blue_level;
    assign results.run_end     = result.run_end;

endmodule

`default_nettype wire

[tb/testbench.sv]
module testbench;

    localparam int PALETTE_BYTES = 48;
    localparam int ITEM_TARGET   = 350;
    localparam int CYCLE_LIMIT   = 8000000;

    typedef enum logic [2:0] {
        AT_HEADER, AT_PALETTE, AT_FONT, AT_CELLS, AT_DONE, AT_BADSIG
    } parse_t;

    typedef struct packed {
        logic [7:0] data;
        logic       ends_file;
    } file_byte_t;

    logic clk;
    logic rst_n;

    xbin_byte_if   file_bytes ();
    xbin_result_if results ();

    xbin_stream_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .results    (results)
    );

    // Parser state mirrored by the predictor.
    parse_t      parse_at;
    logic [16:0] sect_pos;
    logic [15:0] img_w, img_h, col_pos, row_pos;
    logic [7:0]  font_h, hdr_flags, red_hold, green_hold, char_hold, attr_hold;
    logic [1:0]  run_kind;
    logic [6:0]  run_cells;
    logic        char_seen, attr_seen;

    xbin_pkg::result_t byte_results [$];
    xbin_pkg::result_t expected_results [$];
    file_byte_t        byte_feed [$];
    file_byte_t        next_byte;

    int   error_count = 0;
    int   results_seen = 0;
    int   bytes_taken = 0;
    int   byte_total = 0;
    int   hold_mark = 0;
    int   cycle_count = 0;
    int   src_gap = 0;
    int   snk_gap = 0;
    bit   src_calm = 1'b0;
    bit   snk_calm = 1'b0;
    bit   hold_receiver = 1'b0;
    logic byte_took = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Widen a 6-bit color channel to 8 bits.
    function automatic logic [7:0] widen6(input logic [7:0] v);
        return (v << 2) | (v >> 4);
    endfunction

    function automatic logic [16:0] font_size();
        return hdr_flags[4] ? {font_h, 9'd0} : {1'b0, font_h, 8'd0};
    endfunction

    task automatic clear_parser();
        parse_at   = AT_HEADER;
        sect_pos   = '0;
        img_w      = '0;
        img_h      = '0;
        font_h     = '0;
        hdr_flags  = '0;
        red_hold   = '0;
        green_hold = '0;
        col_pos    = '0;
        row_pos    = '0;
        run_kind   = '0;
        run_cells  = '0;
        char_hold  = '0;
        attr_hold  = '0;
        char_seen  = 1'b0;
        attr_seen  = 1'b0;
    endtask

    task automatic start_cells();
        sect_pos  = '0;
        run_cells = '0;
        char_seen = 1'b0;
        attr_seen = 1'b0;
        col_pos   = '0;
        row_pos   = '0;
        parse_at  = (img_h == 16'd0) ? AT_DONE : AT_CELLS;
    endtask

    // The font section is entered only when the flag asks for it and it is not empty.
    task automatic end_palette();
        sect_pos = '0;
        if (hdr_flags[1] && font_size() != 17'd0)
            parse_at = AT_FONT;
        else
            start_cells();
    endtask

    // Emit one cell and advance the position; the row moves on right after
    // the cell that fills it.
    task automatic emit_cell(input logic [7:0] ch, input logic [7:0] attr);
        xbin_pkg::result_t r;
        r             = '0;
        r.kind        = xbin_pkg::KIND_CELL;
        r.cell_column = col_pos;
        r.cell_row    = row_pos;
        r.glyph_code  = ch;
        r.fore_index  = attr[3:0];
        r.back_index  = attr[7:4];
        byte_results.push_back(r);
        col_pos = col_pos + 16'd1;
        if (col_pos == img_w)
        begin
            col_pos = '0;
            row_pos = row_pos + 16'd1;
            if (row_pos == img_h)
                parse_at = AT_DONE;
        end
    endtask

    // One byte of the compressed cell stream.
    task automatic run_step(input logic [7:0] b);
        if (run_cells == 7'd0)
        begin
            run_kind  = b[7:6];
            run_cells = {1'b0, b[5:0]} + 7'd1;
            char_seen = 1'b0;
            attr_seen = 1'b0;
        end
        else
        begin
            case (run_kind)
                xbin_pkg::RUN_PAIRS:
                begin
                    if (!char_seen)
                    begin
                        char_hold = b;
                        char_seen = 1'b1;
                    end
                    else
                    begin
                        emit_cell(char_hold, b);
                        char_seen = 1'b0;
                        run_cells = run_cells - 7'd1;
                    end
                end
                xbin_pkg::RUN_CHAR_ATTRS:
                begin
                    if (!char_seen)
                    begin
                        char_hold = b;
                        char_seen = 1'b1;
                    end
                    else
                    begin
                        attr_hold = b;
                        emit_cell(char_hold, b);
                        run_cells = run_cells - 7'd1;
                    end
                end
                xbin_pkg::RUN_ATTR_CHARS:
                begin
                    if (!attr_seen)
                    begin
                        attr_hold = b;
                        attr_seen = 1'b1;
                    end
                    else
                    begin
                        char_hold = b;
                        emit_cell(b, attr_hold);
                        run_cells = run_cells - 7'd1;
                    end
                end
                default:
                begin
                    if (!char_seen)
                    begin
                        char_hold = b;
                        char_seen = 1'b1;
                    end
                    else
                    begin
                        attr_hold = b;
                        attr_seen = 1'b1;
                        // The repeat stops early once the last row is filled.
                        while (run_cells != 7'd0 && parse_at == AT_CELLS)
                        begin
                            emit_cell(char_hold, attr_hold);
                            run_cells = run_cells - 7'd1;
                        end
                    end
                end
            endcase
        end
    endtask

    // Work out the results of one accepted byte and queue them.
    task automatic decode_byte(input logic [7:0] b, input logic ends);
        xbin_pkg::result_t r;
        logic [16:0]       third;
        byte_results.delete();
        case (parse_at)
            AT_HEADER:
            begin
                if (sect_pos < 17'd5)
                begin
                    if (b != xbin_pkg::SIGNATURE[sect_pos[2:0]])
                    begin
                        r      = '0;
                        r.kind = xbin_pkg::KIND_BADSIG;
                        byte_results.push_back(r);
                        parse_at = AT_BADSIG;
                    end
                    else
                    begin
                        sect_pos = sect_pos + 17'd1;
                    end
                end
                else if (sect_pos == 17'd10)
                begin
                    hdr_flags = b;
                    sect_pos  = '0;
                    if (b[0])
                        parse_at = AT_PALETTE;
                    else
                        end_palette();
                end
                else
                begin
                    case (sect_pos)
                        17'd5:   img_w = {8'd0, b};
                        17'd6:   img_w[15:8] = b;
                        17'd7:   img_h = {8'd0, b};
                        17'd8:   img_h[15:8] = b;
                        default: font_h = b;
                    endcase
                    sect_pos = sect_pos + 17'd1;
                end
            end
            AT_PALETTE:
            begin
                third = 17'(sect_pos / 17'd3);
                case (sect_pos % 17'd3)
                    17'd0: red_hold = b;
                    17'd1: green_hold = b;
                    default:
                    begin
                        r             = '0;
                        r.kind        = xbin_pkg::KIND_PALETTE;
                        r.color_slot  = third[3:0];
                        r.red_level   = widen6(red_hold);
                        r.green_level = widen6(green_hold);
                        r.blue_level  = widen6(b);
                        byte_results.push_back(r);
                    end
                endcase
                sect_pos = sect_pos + 17'd1;
                if (sect_pos >= PALETTE_BYTES)
                    end_palette();
            end
            AT_FONT:
            begin
                sect_pos = sect_pos + 17'd1;
                if (sect_pos >= font_size())
                    start_cells();
            end
            AT_CELLS:
            begin
                if (hdr_flags[2])
                begin
                    run_step(b);
                end
                else if (!char_seen)
                begin
                    char_hold = b;
                    char_seen = 1'b1;
                end
                else
                begin
                    attr_hold = b;
                    char_seen = 1'b0;
                    emit_cell(char_hold, b);
                end
            end
            default: ;
        endcase

        // Mark the last result of this byte.
        if (byte_results.size() != 0)
        begin
            r = byte_results.pop_back();
            r.run_end = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i])
            expected_results.push_back(byte_results[i]);
        if (ends)
            clear_parser();
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic put(input logic [7:0] b);
        file_byte_t fb;
        fb.data      = b;
        fb.ends_file = 1'b0;
        byte_feed.push_back(fb);
    endtask

    task automatic put_random(input int n);
        repeat (n) put(8'($urandom_range(0, 255)));
    endtask

    // Flag the last queued byte as the end of its file.
    task automatic close_file();
        file_byte_t tail;
        tail = byte_feed.pop_back();
        tail.ends_file = 1'b1;
        byte_feed.push_back(tail);
    endtask

    task automatic put_header(input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] gh, input logic [7:0] fl);
        for (int i = 0; i < 5; i++)
            put(xbin_pkg::SIGNATURE[i]);
        put(w[7:0]);
        put(w[15:8]);
        put(h[7:0]);
        put(h[15:8]);
        put(gh);
        put(fl);
    endtask

    // One run byte and the content bytes that its type needs.
    task automatic put_run(input logic [1:0] kind, input int cells);
        logic [5:0] len_code;
        len_code = 6'(cells - 1);
        put({kind, len_code});
        case (kind)
            xbin_pkg::RUN_PAIRS:      put_random(2 * cells);
            xbin_pkg::RUN_CHAR_ATTRS: put_random(1 + cells);
            xbin_pkg::RUN_ATTR_CHARS: put_random(1 + cells);
            default:                  put_random(2);
        endcase
    endtask

    // Cell content for about the given number of cells, raw or compressed.
    task automatic put_cells(input logic [7:0] fl, input int cells);
        int         left;
        int         len;
        logic [1:0] kind;
        left = cells;
        if (!fl[2])
        begin
            put_random(2 * cells);
        end
        else
        begin
            while (left > 0)
            begin
                kind = 2'($urandom_range(0, 3));
                len  = ($urandom_range(0, 9) == 0) ? 64
                     : $urandom_range(1, (left < 8) ? left : 8);
                put_run(kind, len);
                left = left - len;
            end
        end
    endtask

    // Mostly well-formed files with random content; some noise, some broken
    // signatures and some files cut short. Fonts here are always empty.
    task automatic queue_random_file();
        int         roll;
        int         start;
        int         k;
        int         w;
        int         h;
        int         cells;
        int         cut;
        logic [7:0] fl;
        logic [7:0] gh;
        start = byte_feed.size();
        roll  = $urandom_range(0, 99);
        if (roll < 8)
        begin
            put_random($urandom_range(1, 10));
        end
        else if (roll < 16)
        begin
            k = $urandom_range(0, 4);
            for (int i = 0; i < k; i++)
                put(xbin_pkg::SIGNATURE[i]);
            put(xbin_pkg::SIGNATURE[k] ^ 8'($urandom_range(1, 255)));
            put_random($urandom_range(0, 5));
        end
        else
        begin
            w  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
            h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            fl = 8'($urandom_range(0, 255));
            if (fl[1])
                gh = 8'd0;
            else
                gh = 8'($urandom_range(0, 255));
            put_header(16'(w), 16'(h), gh, fl);
            if (fl[0])
                put_random(PALETTE_BYTES);
            cells = ((w == 0) ? 4 : w * h)
                  + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
            put_cells(fl, cells);
            if ($urandom_range(0, 9) == 0 && byte_feed.size() - start > 1)
            begin
                cut = $urandom_range(1, byte_feed.size() - start - 1);
                repeat (cut) void'(byte_feed.pop_back());
            end
        end
        close_file();
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and run control
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n                 = 1'b0;
        file_bytes.valid      = 1'b0;
        file_bytes.data_byte  = 8'd0;
        file_bytes.final_byte = 1'b0;
        results.ready         = 1'b0;
        clear_parser();

        // Bad signature on the first byte, with an ignored byte after it.
        put(8'h00);
        put(xbin_pkg::SIGNATURE[0]);
        close_file();
        // Bad signature on the last signature byte.
        for (int i = 0; i < 4; i++)
            put(xbin_pkg::SIGNATURE[i]);
        put(8'h1B);
        close_file();
        // Raw cells: the pair past the last row is dropped.
        put_header(16'd2, 16'd1, 8'd0, 8'h00);
        put(8'h00);
        put(8'hFF);
        put(8'hFF);
        put(8'h0F);
        put_random(2);
        close_file();
        // Palette with the channel extremes, then one raw cell.
        put_header(16'd1, 16'd1, 8'd0, 8'h01);
        put(8'h3F);
        put(8'h00);
        put(8'hFF);
        put_random(PALETTE_BYTES - 3);
        put_random(2);
        close_file();
        // An empty font is not entered.
        put_header(16'd1, 16'd2, 8'd0, 8'h02);
        put_random(4);
        close_file();
        // Every run type, then a repeat that is cut off by the height.
        hold_mark = byte_feed.size();
        put_header(16'd3, 16'd4, 8'd0, 8'h04);
        put_run(xbin_pkg::RUN_PAIRS, 2);
        put_run(xbin_pkg::RUN_CHAR_ATTRS, 2);
        put_run(xbin_pkg::RUN_ATTR_CHARS, 2);
        put_run(xbin_pkg::RUN_REPEAT, 3);
        put_run(xbin_pkg::RUN_REPEAT, 64);
        put_random(4);
        close_file();
        // A full 64-cell repeat.
        put_header(16'd16, 16'd5, 8'd0, 8'h04);
        put_run(xbin_pkg::RUN_REPEAT, 64);
        put_run(xbin_pkg::RUN_CHAR_ATTRS, 16);
        close_file();
        // Zero height emits no cells.
        put_header(16'd4, 16'd0, 8'd0, 8'h00);
        put_random(6);
        close_file();
        // Zero width: the column just counts up.
        put_header(16'd0, 16'd1, 8'd0, 8'h00);
        put_random(12);
        close_file();
        // Largest width, height and glyph height, cut short inside the font.
        put_header(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFE);
        put_random(8);
        close_file();
        // File that ends inside the header.
        for (int i = 0; i < 5; i++)
            put(xbin_pkg::SIGNATURE[i]);
        put_random(2);
        close_file();

        while (byte_feed.size() < ITEM_TARGET)
            queue_random_file();
        byte_total = byte_feed.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < byte_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hold the receiver off for a long stretch while cells are being decoded.
    initial
    begin
        wait (rst_n);
        while (bytes_taken < hold_mark + 12)
            @(posedge clk);
        hold_receiver = 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------

    // Idle length after a transfer: mostly none, some short, a few long.
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer the next byte once the current one has transferred.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                src_calm = !src_calm;
            if (!file_bytes.valid || byte_took)
            begin
                if (src_gap > 0)
                begin
                    file_bytes.valid <= 1'b0;
                    src_gap--;
                end
                else if (byte_feed.size() != 0)
                begin
                    next_byte = byte_feed.pop_front();
                    file_bytes.valid      <= 1'b1;
                    file_bytes.data_byte  <= next_byte.data;
                    file_bytes.final_byte <= next_byte.ends_file;
                    src_gap = pick_gap(src_calm);
                end
                else
                begin
                    file_bytes.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready with random stalls and one forced long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                snk_calm = !snk_calm;
            if (hold_receiver)
            begin
                results.ready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                results.ready <= 1'b0;
                snk_gap--;
            end
            else
            begin
                results.ready <= 1'b1;
                snk_gap = pick_gap(snk_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("Mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        xbin_pkg::result_t want;
        if (rst_n)
        begin
            // Compare each result transfer with the oldest expectation.
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result arrived with none expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(results.kind), 16'(want.kind));
                    check_field("cell_column", results.cell_column, want.cell_column);
                    check_field("cell_row", results.cell_row, want.cell_row);
                    check_field("glyph_code", 16'(results.glyph_code), 16'(want.glyph_code));
                    check_field("fore_index", 16'(results.fore_index), 16'(want.fore_index));
                    check_field("back_index", 16'(results.back_index), 16'(want.back_index));
                    check_field("color_slot", 16'(results.color_slot), 16'(want.color_slot));
                    check_field("red_level", 16'(results.red_level), 16'(want.red_level));
                    check_field("green_level", 16'(results.green_level),
                                16'(want.green_level));
                    check_field("blue_level", 16'(results.blue_level), 16'(want.blue_level));
                    check_field("run_end", 16'(results.run_end), 16'(want.run_end));
                end
                results_seen++;
            end
            // Predict from each byte transfer.
            if (file_bytes.valid && file_bytes.ready)
            begin
                decode_byte(file_bytes.data_byte, file_bytes.final_byte);
                bytes_taken++;
            end
            byte_took <= file_bytes.valid && file_bytes.ready;
        end
    end

endmodule
